>>> rtl/core/a5m_pkg.sv
// Shared types and constants for the AX.25 monitor text core.
// No dependencies; a5m_packer, a5m_text_seq and the top level of the core refer to this package.
`timescale 1ns / 1ps
`default_nettype none
package a5m_pkg;

  localparam int MAX_RELAYS_DEF = 6;
  localparam int ADDR_LEN       = 7;
  localparam int MAX_RESULTS    = 12;
  localparam int RELAY_W        = 4;

  localparam logic [7:0] CTRL_UI  = 8'h03;
  localparam logic [7:0] PID_NONE = 8'hF0;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_STAR  = 8'h2a;

  typedef enum logic [2:0] {
    PH_TYPE, PH_ADDR, PH_CTRL, PH_PID, PH_DATA, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    JOB_REJECT, JOB_HEADER, JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [7:0]         data;
    logic               last;
    logic [RELAY_W-1:0] relays;
  } job_t;

  typedef enum logic [1:0] {
    PK_CHAR, PK_FLUSH, PK_REJECT
  } pk_op_t;

  typedef struct packed {
    logic       valid;
    pk_op_t     op;
    logic [7:0] ch;
    logic       last;
  } pk_cmd_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_REJ, SQ_LOAD, SQ_EMIT, SQ_COLON, SQ_DATA, SQ_CR, SQ_LF, SQ_FLUSH
  } seq_state_t;

endpackage
`default_nettype wire

>>> rtl/core/a5m_in_if.sv
// Input channel: one frame byte per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface a5m_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/core/a5m_out_if.sv
// Result channel: a chunk of up to eight text characters per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface a5m_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] text_chars;
  logic [3:0]  char_count;
  logic        line_done;
  logic        frame_dropped;

  modport source (output valid, output text_chars, output char_count,
                  output line_done, output frame_dropped, input ready);
  modport sink   (input valid, input text_chars, input char_count,
                  input line_done, input frame_dropped, output ready);
endinterface
`default_nettype wire

>>> rtl/core/a5m_addr_mem.sv
// Address byte store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module a5m_addr_mem #(
  parameter int DEPTH = 56,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/a5m_packer.sv
// Packs a character stream into chunks of up to eight and holds the result register.
// Depends on a5m_pkg and a5m_out_if.
`timescale 1ns / 1ps
`default_nettype none
module a5m_packer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire a5m_pkg::pk_cmd_t cmd,
  output logic                  cmd_ready,
  a5m_out_if.source             out_ch
);

  logic [7:0]  byte_r [8];
  logic [7:0]  byte_nxt [8];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  chunks_r, chunks_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_chars_r, out_chars_nxt;
  logic [3:0]  out_cnt_r, out_cnt_nxt;
  logic        out_done_r, out_done_nxt;
  logic        out_drop_r, out_drop_nxt;
  logic [63:0] word;
  logic        can_load;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = byte_r[i];
    end
  end

  assign can_load = !out_vld_r || out_ch.ready;

  always_comb begin
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    chunks_nxt    = chunks_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_chars_nxt = out_chars_r;
    out_cnt_nxt   = out_cnt_r;
    out_done_nxt  = out_done_r;
    out_drop_nxt  = out_drop_r;
    cmd_ready     = 1'b0;
    if (cmd.valid) begin
      case (cmd.op)
        a5m_pkg::PK_CHAR: begin
          if (cnt_r == 4'd8) begin
            if (chunks_r == 4'(a5m_pkg::MAX_RESULTS - 1)) begin
              // final chunk slot: hold it for the flush, drop excess text
              cmd_ready = 1'b1;
            end else if (can_load) begin
              out_vld_nxt   = 1'b1;
              out_chars_nxt = word;
              out_cnt_nxt   = 4'd8;
              out_done_nxt  = 1'b0;
              out_drop_nxt  = 1'b0;
              chunks_nxt    = chunks_r + 4'd1;
              for (int i = 0; i < 8; i++) byte_nxt[i] = 8'h00;
              byte_nxt[0]   = cmd.ch;
              cnt_nxt       = 4'd1;
              cmd_ready     = 1'b1;
            end
          end else begin
            byte_nxt[cnt_r[2:0]] = cmd.ch;
            cnt_nxt   = cnt_r + 4'd1;
            cmd_ready = 1'b1;
          end
        end
        a5m_pkg::PK_FLUSH: begin
          if (cnt_r != 4'd0) begin
            if (can_load) begin
              out_vld_nxt   = 1'b1;
              out_chars_nxt = word;
              out_cnt_nxt   = cnt_r;
              out_done_nxt  = cmd.last;
              out_drop_nxt  = 1'b0;
              for (int i = 0; i < 8; i++) byte_nxt[i] = 8'h00;
              cnt_nxt       = 4'd0;
              chunks_nxt    = 4'd0;
              cmd_ready     = 1'b1;
            end
          end else begin
            chunks_nxt = 4'd0;
            cmd_ready  = 1'b1;
          end
        end
        a5m_pkg::PK_REJECT: begin
          if (can_load) begin
            out_vld_nxt   = 1'b1;
            out_chars_nxt = 64'd0;
            out_cnt_nxt   = 4'd0;
            out_done_nxt  = 1'b1;
            out_drop_nxt  = 1'b1;
            cmd_ready     = 1'b1;
          end
        end
        default: cmd_ready = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 4'd0;
      chunks_r  <= 4'd0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < 8; i++) byte_r[i] <= 8'h00;
    end else begin
      cnt_r     <= cnt_nxt;
      chunks_r  <= chunks_nxt;
      out_vld_r <= out_vld_nxt;
      byte_r    <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_chars_r <= out_chars_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_done_r  <= out_done_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.text_chars    = out_chars_r;
  assign out_ch.char_count    = out_cnt_r;
  assign out_ch.line_done     = out_done_r;
  assign out_ch.frame_dropped = out_drop_r;

  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_dropped |-> out_ch.line_done && out_ch.char_count == 4'd0)
    else $error("rejection transaction carries text");
  a_text_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_dropped |-> out_ch.char_count != 4'd0 &&
      out_ch.char_count <= 4'd8)
    else $error("text transaction with bad character count");
  a_chunk_cap: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_r <= 4'(a5m_pkg::MAX_RESULTS - 1))
    else $error("chunk counter past result limit");

endmodule
`default_nettype wire

>>> rtl/core/a5m_text_seq.sv
// Text sequencer: reads addresses from the store, generates header, payload and line-end characters.
// Depends on a5m_pkg; feeds a5m_packer.
`timescale 1ns / 1ps
`default_nettype none
module a5m_text_seq #(
  parameter int MAX_RELAYS = a5m_pkg::MAX_RELAYS_DEF,
  parameter int DEPTH      = (2 + MAX_RELAYS) * a5m_pkg::ADDR_LEN,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_vld,
  input  wire a5m_pkg::job_t    job,
  output logic                  busy,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  wire logic [7:0]       rd_data,
  output a5m_pkg::pk_cmd_t      cmd,
  input  wire logic             cmd_ready
);

  localparam int SW = a5m_pkg::RELAY_W + 1;

  a5m_pkg::seq_state_t state_r, state_nxt;
  a5m_pkg::job_t       job_r, job_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [3:0]          ld_r, ld_nxt;
  logic [3:0]          step_r, step_nxt;
  logic [7:0]          buf_r [7];
  logic                nxh_r;
  logic                rd_vld_r;
  logic [2:0]          rd_sel_r;

  logic                is_digi, more_slots, need_nx, nonempty, emit, advance;
  logic [6:0]          keep;
  logic [3:0]          ssid, digit;
  logic [7:0]          ch;
  logic [AW:0]         addr_wide;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      keep[i] = {1'b0, buf_r[i][7:1]} != a5m_pkg::CH_SPACE;
    end
    keep[6]    = 1'b0;
    ssid       = buf_r[6][4:1];
    digit      = (ssid >= 4'd10) ? ssid - 4'd10 : ssid;
    nonempty   = (|keep) || (ssid != 4'd0);
    is_digi    = slot_r >= SW'(2);
    more_slots = (slot_r + SW'(1)) < ({1'b0, job_r.relays} + SW'(2));
    need_nx    = is_digi && more_slots;
  end

  // read address: six call bytes, SSID byte, then the next digipeater's SSID byte (else the own SSID byte again)
  always_comb begin
    if (ld_r < 4'd7) begin
      addr_wide = {1'b0, base_r} + (AW + 1)'(ld_r);
    end else if (need_nx) begin
      addr_wide = {1'b0, base_r} + (AW + 1)'(2 * a5m_pkg::ADDR_LEN - 1);
    end else begin
      addr_wide = {1'b0, base_r} + (AW + 1)'(a5m_pkg::ADDR_LEN - 1);
    end
    rd_addr = addr_wide[AW-1:0];
    rd_en   = (state_r == a5m_pkg::SQ_LOAD) && (ld_r < 4'd8);
  end

  always_comb begin
    emit = 1'b0;
    ch   = a5m_pkg::CH_SPACE;
    case (step_r)
      4'd0: begin
        if (slot_r == SW'(1)) begin
          emit = 1'b1;
          ch   = a5m_pkg::CH_GT;
        end else if (is_digi && nonempty) begin
          emit = 1'b1;
          ch   = a5m_pkg::CH_COMMA;
        end
      end
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
        emit = keep[step_r[2:0] - 3'd1];
        ch   = {1'b0, buf_r[step_r[2:0] - 3'd1][7:1]};
      end
      4'd7: begin
        emit = ssid != 4'd0;
        ch   = a5m_pkg::CH_DASH;
      end
      4'd8: begin
        emit = ssid >= 4'd10;
        ch   = a5m_pkg::CH_ONE;
      end
      4'd9: begin
        emit = ssid != 4'd0;
        ch   = a5m_pkg::CH_ZERO + {4'd0, digit};
      end
      4'd10: begin
        emit = is_digi && nonempty && buf_r[6][7] && !nxh_r;
        ch   = a5m_pkg::CH_STAR;
      end
      default: emit = 1'b0;
    endcase
    advance = !emit || cmd_ready;
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    slot_nxt  = slot_r;
    base_nxt  = base_r;
    ld_nxt    = ld_r;
    step_nxt  = step_r;
    cmd       = '{valid: 1'b0, op: a5m_pkg::PK_CHAR, ch: 8'h00, last: 1'b0};
    case (state_r)
      a5m_pkg::SQ_IDLE: begin
        if (job_vld) begin
          job_nxt = job;
          case (job.kind)
            a5m_pkg::JOB_REJECT: state_nxt = a5m_pkg::SQ_REJ;
            a5m_pkg::JOB_HEADER: begin
              state_nxt = a5m_pkg::SQ_LOAD;
              slot_nxt  = '0;
              base_nxt  = AW'(a5m_pkg::ADDR_LEN);
              ld_nxt    = 4'd0;
            end
            a5m_pkg::JOB_DATA: state_nxt = a5m_pkg::SQ_DATA;
            default: state_nxt = a5m_pkg::SQ_IDLE;
          endcase
        end
      end
      a5m_pkg::SQ_REJ: begin
        cmd = '{valid: 1'b1, op: a5m_pkg::PK_REJECT, ch: 8'h00, last: 1'b1};
        if (cmd_ready) state_nxt = a5m_pkg::SQ_IDLE;
      end
      a5m_pkg::SQ_LOAD: begin
        // last read data (the next digipeater's H bit) lands in nxh_r at the edge that leaves this state
        if (ld_r == 4'd8) begin
          state_nxt = a5m_pkg::SQ_EMIT;
          step_nxt  = 4'd0;
        end else begin
          ld_nxt = ld_r + 4'd1;
        end
      end
      a5m_pkg::SQ_EMIT: begin
        cmd = '{valid: emit, op: a5m_pkg::PK_CHAR, ch: ch, last: 1'b0};
        if (advance) begin
          if (step_r == 4'd10) begin
            if (more_slots) begin
              slot_nxt  = slot_r + SW'(1);
              ld_nxt    = 4'd0;
              state_nxt = a5m_pkg::SQ_LOAD;
              if (slot_r == '0) begin
                base_nxt = '0;
              end else if (slot_r == SW'(1)) begin
                base_nxt = AW'(2 * a5m_pkg::ADDR_LEN);
              end else begin
                base_nxt = base_r + AW'(a5m_pkg::ADDR_LEN);
              end
            end else begin
              state_nxt = a5m_pkg::SQ_COLON;
            end
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      a5m_pkg::SQ_COLON: begin
        cmd = '{valid: 1'b1, op: a5m_pkg::PK_CHAR, ch: a5m_pkg::CH_COLON, last: 1'b0};
        if (cmd_ready) state_nxt = job_r.last ? a5m_pkg::SQ_CR : a5m_pkg::SQ_FLUSH;
      end
      a5m_pkg::SQ_DATA: begin
        cmd.valid = 1'b1;
        cmd.op    = a5m_pkg::PK_CHAR;
        cmd.ch    = (job_r.data >= a5m_pkg::CH_SPACE && job_r.data <= a5m_pkg::CH_TILDE) ?
                    job_r.data : a5m_pkg::CH_SPACE;
        if (cmd_ready) state_nxt = job_r.last ? a5m_pkg::SQ_CR : a5m_pkg::SQ_FLUSH;
      end
      a5m_pkg::SQ_CR: begin
        cmd = '{valid: 1'b1, op: a5m_pkg::PK_CHAR, ch: a5m_pkg::CH_CR, last: 1'b0};
        if (cmd_ready) state_nxt = a5m_pkg::SQ_LF;
      end
      a5m_pkg::SQ_LF: begin
        cmd = '{valid: 1'b1, op: a5m_pkg::PK_CHAR, ch: a5m_pkg::CH_LF, last: 1'b0};
        if (cmd_ready) state_nxt = a5m_pkg::SQ_FLUSH;
      end
      a5m_pkg::SQ_FLUSH: begin
        cmd = '{valid: 1'b1, op: a5m_pkg::PK_FLUSH, ch: 8'h00, last: job_r.last};
        if (cmd_ready) state_nxt = a5m_pkg::SQ_IDLE;
      end
      default: state_nxt = a5m_pkg::SQ_IDLE;
    endcase
  end

  assign busy = state_r != a5m_pkg::SQ_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= a5m_pkg::SQ_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    slot_r   <= slot_nxt;
    base_r   <= base_nxt;
    ld_r     <= ld_nxt;
    step_r   <= step_nxt;
    rd_sel_r <= ld_r[2:0];
    if (rd_vld_r) begin
      if (rd_sel_r == 3'd7) begin
        nxh_r <= rd_data[7] && need_nx;
      end else begin
        buf_r[rd_sel_r] <= rd_data;
      end
    end
  end

  a_read_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == a5m_pkg::SQ_LOAD)
    else $error("read data returned outside address load");
  a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !$rose(state_r == a5m_pkg::SQ_LOAD) || $past(state_r) == a5m_pkg::SQ_IDLE ||
      $past(state_r) == a5m_pkg::SQ_EMIT)
    else $error("address load entered from wrong state");

endmodule
`default_nettype wire

>>> rtl/core/ax25_frame_to_monitor_text_core.sv
// Top level of the AX.25 monitor text core: frame parser, address store, sequencer, packer.
// Depends on a5m_pkg, a5m_in_if, a5m_out_if, a5m_addr_mem, a5m_text_seq, a5m_packer.
`timescale 1ns / 1ps
`default_nettype none
// Takes a KISS frame one byte per transaction and returns the monitor line
// "from>to,digi*,...:payload" CR LF in chunks of up to eight characters, or a
// single rejection transaction. Type, address and control bytes give no result
// unless the frame is rejected. On the PID byte the sequencer builds the header
// from the address store: each address is loaded through the single store read
// port and then rendered in eleven character steps; while the header is built,
// also while the result side stalls, no byte is accepted. Each payload byte
// passes through a character step and a flush, the final one also through CR LF.
// The output register lets the next byte in while a chunk waits to be taken.
// The address store needs no clearing after reset.
module ax25_frame_to_monitor_text_core #(
  parameter int MAX_RELAYS = a5m_pkg::MAX_RELAYS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  a5m_in_if.sink    in_chan,
  a5m_out_if.source out_chan
);

  localparam int DEPTH = (2 + MAX_RELAYS) * a5m_pkg::ADDR_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(DEPTH + a5m_pkg::ADDR_LEN);
  localparam int RW    = a5m_pkg::RELAY_W;

  a5m_pkg::phase_t  phase_r, phase_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [BW-1:0]    bnd_r, bnd_nxt;
  logic [RW-1:0]    grp_r, grp_nxt;
  logic [RW-1:0]    relay_r, relay_nxt;

  logic             acc, busy, wr_en, rd_en, job_vld, cmd_ready, rej;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data, b;
  logic             fend;
  a5m_pkg::job_t    job;
  a5m_pkg::pk_cmd_t cmd;

  assign in_chan.ready = !busy;
  assign acc  = in_chan.valid && in_chan.ready;
  assign b    = in_chan.frame_byte;
  assign fend = in_chan.frame_end;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    bnd_nxt   = bnd_r;
    grp_nxt   = grp_r;
    relay_nxt = relay_r;
    wr_en     = 1'b0;
    job_vld   = 1'b0;
    rej       = 1'b0;
    job       = '{kind: a5m_pkg::JOB_REJECT, data: b, last: fend, relays: relay_r};
    if (acc) begin
      case (phase_r)
        a5m_pkg::PH_TYPE: begin
          idx_nxt   = '0;
          relay_nxt = '0;
          bnd_nxt   = BW'(2 * a5m_pkg::ADDR_LEN - 1);
          grp_nxt   = '0;
          if (b[3:0] != 4'd0 || fend) rej = 1'b1;
          else phase_nxt = a5m_pkg::PH_ADDR;
        end
        a5m_pkg::PH_ADDR: begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + AW'(1);
          // end-bit check at the SSID byte of each address from the source on
          if ({{(BW - AW){1'b0}}, idx_r} == bnd_r) begin
            bnd_nxt = bnd_r + BW'(a5m_pkg::ADDR_LEN);
            grp_nxt = grp_r + RW'(1);
            if (b[0]) begin
              relay_nxt = grp_r;
              phase_nxt = a5m_pkg::PH_CTRL;
            end else if (grp_r >= RW'(MAX_RELAYS)) begin
              rej = 1'b1;
            end
          end
          if (fend) rej = 1'b1;
        end
        a5m_pkg::PH_CTRL: begin
          if (b != a5m_pkg::CTRL_UI || fend) rej = 1'b1;
          else phase_nxt = a5m_pkg::PH_PID;
        end
        a5m_pkg::PH_PID: begin
          if (b != a5m_pkg::PID_NONE) begin
            rej = 1'b1;
          end else begin
            job_vld   = 1'b1;
            job.kind  = a5m_pkg::JOB_HEADER;
            phase_nxt = fend ? a5m_pkg::PH_TYPE : a5m_pkg::PH_DATA;
          end
        end
        a5m_pkg::PH_DATA: begin
          job_vld   = 1'b1;
          job.kind  = a5m_pkg::JOB_DATA;
          phase_nxt = fend ? a5m_pkg::PH_TYPE : a5m_pkg::PH_DATA;
        end
        a5m_pkg::PH_SKIP: begin
          if (fend) phase_nxt = a5m_pkg::PH_TYPE;
        end
        default: phase_nxt = a5m_pkg::PH_TYPE;
      endcase
      if (rej) begin
        job_vld   = 1'b1;
        job.kind  = a5m_pkg::JOB_REJECT;
        phase_nxt = fend ? a5m_pkg::PH_TYPE : a5m_pkg::PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= a5m_pkg::PH_TYPE;
      idx_r   <= '0;
      relay_r <= '0;
      bnd_r   <= BW'(2 * a5m_pkg::ADDR_LEN - 1);
      grp_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      relay_r <= relay_nxt;
      bnd_r   <= bnd_nxt;
      grp_r   <= grp_nxt;
    end
  end

  a5m_addr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a5m_text_seq #(.MAX_RELAYS(MAX_RELAYS), .DEPTH(DEPTH), .AW(AW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job       (job),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  a5m_packer u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_chan)
  );

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("address store written during header build");
  a_job_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld |-> !busy)
    else $error("job issued while sequencer busy");
  a_header_has_end: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == a5m_pkg::PH_PID |-> relay_r <= RW'(MAX_RELAYS))
    else $error("relay count beyond limit at header start");

endmodule
`default_nettype wire

>>> sim/ax25_frame_to_monitor_text_checker.sv
// Checker for the AX.25 monitor text core: watches both channels, predicts the
// text chunks of each frame and compares them. Depends on a5m_pkg and the channel interfaces.
`timescale 1ns / 1ps
module ax25_frame_to_monitor_text_checker (
  input  logic clk,
  input  logic rst_n,
  a5m_in_if    in_mon,
  a5m_out_if   out_mon,
  output int   errors,
  output int   pending
);
  import a5m_pkg::*;

  localparam int RELAYS      = MAX_RELAYS_DEF;
  localparam int STORE_DEPTH = (2 + RELAYS) * ADDR_LEN;

  typedef struct {
    logic [63:0] text_chars;
    logic [3:0]  char_count;
    logic        line_done;
    logic        frame_dropped;
  } chunk_t;

  chunk_t          chunk_q[$];
  logic [7:0]      addr_mem[STORE_DEPTH];
  logic [5:0]      addr_idx;
  phase_t          phase;
  logic [2:0]      relays;
  byte unsigned    line_txt[$];
  byte unsigned    call_txt[$];

  assign pending = chunk_q.size();

  function automatic logic [7:0] mem_at(int i);
    return (i < STORE_DEPTH) ? addr_mem[i] : 8'h00;
  endfunction

  // Render one callsign into call_txt: shifted chars without spaces, then -SSID.
  function automatic void render_call(int base);
    logic [7:0] c;
    int ssid;
    call_txt.delete();
    for (int i = 0; i < 6; i++) begin
      c = (mem_at(base + i) >> 1) & 8'h7f;
      if (c != CH_SPACE) call_txt.push_back(c);
    end
    ssid = int'((mem_at(base + 6) & 8'h1e) >> 1);
    if (ssid != 0) begin
      call_txt.push_back(CH_DASH);
      if (ssid >= 10) call_txt.push_back(CH_ONE);
      call_txt.push_back(8'(CH_ZERO + ssid % 10));
    end
  endfunction

  function automatic void build_header();
    int base;
    bit h_bit, next_h;
    logic [7:0] ssid_b, nx_b;
    line_txt.delete();
    render_call(ADDR_LEN);
    line_txt = {line_txt, call_txt};
    line_txt.push_back(CH_GT);
    render_call(0);
    line_txt = {line_txt, call_txt};
    for (int k = 0; k < relays; k++) begin
      base = 2 * ADDR_LEN + k * ADDR_LEN;
      ssid_b = mem_at(base + 6);
      nx_b = mem_at(base + ADDR_LEN + 6);
      h_bit = ssid_b[7];
      next_h = (k + 1 < relays) ? nx_b[7] : 1'b0;
      render_call(base);
      // blank digipeaters vanish, comma included
      if (call_txt.size() != 0) begin
        line_txt.push_back(CH_COMMA);
        line_txt = {line_txt, call_txt};
        if (h_bit && !next_h) line_txt.push_back(CH_STAR);
      end
    end
    line_txt.push_back(CH_COLON);
  endfunction

  function automatic void emit_line(bit done);
    int pos;
    int n;
    chunk_t ck;
    pos = 0;
    n = 0;
    while (pos < line_txt.size() && n < MAX_RESULTS) begin
      ck = '{64'h0, 4'd0, 1'b0, 1'b0};
      for (int j = 0; j < 8 && pos < line_txt.size(); j++) begin
        ck.text_chars[8*j +: 8] = line_txt[pos];
        ck.char_count++;
        pos++;
      end
      chunk_q.push_back(ck);
      n++;
    end
    if (n > 0 && done) chunk_q[chunk_q.size() - 1].line_done = 1'b1;
  endfunction

  function automatic void drop_frame(bit last);
    phase = last ? PH_TYPE : PH_SKIP;
    chunk_q.push_back('{64'h0, 4'd0, 1'b1, 1'b1});
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit last);
    int pos;
    int k;
    case (phase)
      PH_ADDR: begin
        pos = addr_idx;
        if (pos < STORE_DEPTH) addr_mem[pos] = b;
        addr_idx = 6'(pos + 1);
        if (pos >= 13 && (pos - 13) % ADDR_LEN == 0) begin
          k = (pos - 13) / ADDR_LEN;
          if (b[0]) begin
            relays = 3'(k);
            phase = PH_CTRL;
          end else if (k >= RELAYS) begin
            drop_frame(last);
            return;
          end
        end
        if (last) drop_frame(last);
      end
      PH_CTRL: begin
        if (b != CTRL_UI || last) drop_frame(last);
        else phase = PH_PID;
      end
      PH_PID: begin
        if (b != PID_NONE) begin
          drop_frame(last);
        end else begin
          build_header();
          if (last) begin
            line_txt.push_back(CH_CR);
            line_txt.push_back(CH_LF);
            phase = PH_TYPE;
          end else begin
            phase = PH_DATA;
          end
          emit_line(last);
        end
      end
      PH_DATA: begin
        line_txt.delete();
        line_txt.push_back((b >= CH_SPACE && b <= CH_TILDE) ? b : CH_SPACE);
        if (last) begin
          line_txt.push_back(CH_CR);
          line_txt.push_back(CH_LF);
          phase = PH_TYPE;
        end
        emit_line(last);
      end
      PH_SKIP: begin
        if (last) phase = PH_TYPE;
      end
      PH_TYPE: begin
        addr_idx = '0;
        relays = '0;
        if (b[3:0] != 4'h0 || last) drop_frame(last);
        else phase = PH_ADDR;
      end
      default: phase = PH_TYPE;
    endcase
  endfunction

  always @(posedge clk) begin
    chunk_t want;
    if (!rst_n) begin
      addr_idx = '0;
      relays = '0;
      phase = PH_TYPE;
      chunk_q.delete();
      errors = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.frame_byte, in_mon.frame_end);
      if (out_mon.valid && out_mon.ready) begin
        if (chunk_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = chunk_q.pop_front();
          if (out_mon.text_chars !== want.text_chars) begin
            $error("text_chars expected %h actual %h", want.text_chars, out_mon.text_chars);
            errors++;
          end
          if (out_mon.char_count !== want.char_count) begin
            $error("char_count expected %0d actual %0d", want.char_count, out_mon.char_count);
            errors++;
          end
          if (out_mon.line_done !== want.line_done) begin
            $error("line_done expected %0d actual %0d", want.line_done, out_mon.line_done);
            errors++;
          end
          if (out_mon.frame_dropped !== want.frame_dropped) begin
            $error("frame_dropped expected %0d actual %0d", want.frame_dropped,
                   out_mon.frame_dropped);
            errors++;
          end
        end
      end
    end
  end
endmodule

>>> sim/ax25_frame_to_monitor_text_core_tb.sv
// Top of the AX.25 monitor text core testbench: clock, reset, frame stimulus,
// result-side stalls, watchdog and verdict. Depends on the core, its interfaces and the checker.
`timescale 1ns / 1ps
module ax25_frame_to_monitor_text_core_tb;
  import a5m_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_BYTES = 130;

  typedef enum {
    FR_GOOD, FR_BAD_TYPE, FR_TYPE_END, FR_NO_END, FR_BAD_CTRL, FR_BAD_PID,
    FR_EARLY_END, FR_PID_END
  } frame_kind_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   bytes_sent;
  bit   calm;
  byte unsigned frame_q[$];

  a5m_in_if  in_chan();
  a5m_out_if out_chan();

  ax25_frame_to_monitor_text_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  ax25_frame_to_monitor_text_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Result side: stall for a drawn number of cycles, then take one transaction.
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    in_chan.valid      <= 1'b1;
    in_chan.frame_byte <= b;
    in_chan.frame_end  <= last;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] b;
    do b = 8'($urandom); while (b == v);
    return b;
  endfunction

  function automatic logic [7:0] call_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 8'(8'h41 + $urandom_range(0, 25));
    if (pick < 7) return 8'(8'h30 + $urandom_range(0, 9));
    if (pick < 9) return CH_SPACE;
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic void add_address(bit end_bit, bit blank);
    logic [7:0] ssid;
    logic [7:0] c;
    for (int i = 0; i < 6; i++) begin
      c = blank ? CH_SPACE : call_char();
      frame_q.push_back({c[6:0], 1'b0});
    end
    ssid = 8'($urandom);
    if (blank) ssid[4:1] = 4'h0;
    ssid[0] = end_bit;
    frame_q.push_back(ssid);
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] edges[6] = '{8'h00, 8'hff, 8'h1f, 8'h20, 8'h7e, 8'h7f};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  task automatic send_frame(frame_kind_t kind, int digis, int payload);
    int n_addr;
    frame_q.delete();
    if (kind == FR_BAD_TYPE)
      frame_q.push_back({4'($urandom), 4'($urandom_range(1, 15))});
    else
      frame_q.push_back({4'($urandom), 4'h0});
    if (kind == FR_BAD_TYPE) begin
      repeat (payload) frame_q.push_back(8'($urandom));
    end else if (kind != FR_TYPE_END) begin
      n_addr = (kind == FR_NO_END) ? 2 + MAX_RELAYS_DEF + 1 : 2 + digis;
      for (int a = 0; a < n_addr; a++)
        add_address(kind != FR_NO_END && a == n_addr - 1,
                     a >= 2 && $urandom_range(0, 3) == 0);
      if (kind == FR_NO_END) begin
        repeat (payload) frame_q.push_back(8'($urandom));
      end else if (kind != FR_EARLY_END || $urandom_range(0, 1) == 1) begin
        frame_q.push_back(kind == FR_BAD_CTRL ? other_than(CTRL_UI) : CTRL_UI);
        if (kind != FR_EARLY_END) begin
          frame_q.push_back(kind == FR_BAD_PID ? other_than(PID_NONE) : PID_NONE);
          if (kind != FR_PID_END) repeat (payload) frame_q.push_back(payload_byte());
        end
      end
    end
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  initial begin
    frame_kind_t kind;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.frame_byte <= 8'h00;
    in_chan.frame_end <= 1'b0;
    bytes_sent = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(FR_BAD_TYPE, 0, 0);
    send_frame(FR_TYPE_END, 0, 0);
    send_frame(FR_PID_END, 0, 0);
    send_frame(FR_GOOD, 0, 1);
    drain();

    while (bytes_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 13))
        0:       kind = FR_BAD_TYPE;
        1:       kind = FR_TYPE_END;
        2:       kind = FR_NO_END;
        3:       kind = FR_BAD_CTRL;
        4:       kind = FR_BAD_PID;
        5:       kind = FR_EARLY_END;
        6:       kind = FR_PID_END;
        default: kind = FR_GOOD;
      endcase
      send_frame(kind, $urandom_range(0, MAX_RELAYS_DEF), $urandom_range(0, 12));
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
